FILE: rtl/spm_pkg.sv
// constants and types shared by the stream pattern masker
package spm_pkg;

  localparam int PATTERN_MAX = 8;
  localparam int BYTE_W      = 8;
  localparam int PAT_W       = PATTERN_MAX * BYTE_W;
  localparam int LEN_W       = 4;
  localparam int HELD_W      = 3;
  localparam int MASK_W      = 3;
  localparam int CFG_IDX_W   = 1;

  localparam logic [BYTE_W-1:0] STAR_BYTE = 8'h2A;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 1'd1;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef byte_t window_t [PATTERN_MAX];

endpackage

FILE: rtl/stream_pattern_masker.sv
// stream pattern masker: replaces occurrences of a configured byte pattern with asterisks
//
// Byte stream in, byte stream out, valid/stall on both sides. Each transaction carries one
// byte and an end-of-stream flag; every occurrence of the configured pattern (leftmost,
// non-overlapping) comes out as '*' bytes, and with a pattern length of 0 bytes pass
// unchanged. Output lags input by pattern_length-1 bytes, since the block holds that many
// bytes in its window before it can decide on the oldest one. In steady state and while
// out_stall is low, one byte is taken and one is given each cycle. The single output
// register gives at most one byte per cycle, so a transaction that releases several bytes
// holds the input until they have all left: after the end-of-stream byte the held bytes
// drain while input waits, and the first byte after the pattern length was lowered waits
// while the surplus held bytes are released. out_last marks the final byte of the stream.
// Write the configuration registers only while the block is idle; a length above 8 acts as 8.
module stream_pattern_masker (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration write port
  input  logic                            cfg_we,
  input  logic [spm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [spm_pkg::PAT_W-1:0]       cfg_wdata,
  // input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [spm_pkg::BYTE_W-1:0]      in_data_byte,
  input  logic                            in_end_of_stream,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [spm_pkg::BYTE_W-1:0]      out_byte,
  output logic                            out_last
);
  import spm_pkg::*;

  // configuration registers
  logic [PAT_W-1:0]  pat_r;
  logic [LEN_W-1:0]  pat_len_r;

  // input register
  logic              ib_valid_r;
  byte_t             ib_byte_r;
  logic              ib_eos_r;

  // window state
  window_t           win_r, win_nxt;
  logic [HELD_W-1:0] held_r, held_nxt;
  logic [MASK_W-1:0] mask_r, mask_nxt;
  logic              drain_r, drain_nxt;

  // output register
  logic              out_valid_r;
  byte_t             out_byte_r;
  logic              out_last_r;

  // datapath signals
  logic [LEN_W-1:0]  len_eff;
  logic [LEN_W-1:0]  held_ext;
  logic [LEN_W-1:0]  newheld;
  window_t           w_push;
  logic              match;
  logic              out_free;
  logic              consume;
  logic              emit;
  byte_t             emit_byte;
  logic              emit_last;

  assign len_eff  = (pat_len_r > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : pat_len_r;
  assign held_ext = {1'b0, held_r};
  assign newheld  = held_ext + LEN_W'(1);
  assign out_free = !out_valid_r || !out_stall;

  // window with the waiting byte written behind the held ones
  always_comb begin
    for (int k = 0; k < PATTERN_MAX; k++) begin
      w_push[k] = (held_r == HELD_W'(k)) ? ib_byte_r : win_r[k];
    end
  end

  // parallel compare of the pushed window against the pattern, positions below length only
  always_comb begin
    match = 1'b1;
    for (int k = 0; k < PATTERN_MAX; k++) begin
      if ((LEN_W'(k) < len_eff) && (w_push[k] != pat_r[BYTE_W*k +: BYTE_W])) begin
        match = 1'b0;
      end
    end
  end

  // one pop per cycle at most: eos drain first, then surplus from a lowered length,
  // then the waiting transaction itself
  always_comb begin
    logic star;
    star      = 1'b0;
    win_nxt   = win_r;
    held_nxt  = held_r;
    mask_nxt  = mask_r;
    drain_nxt = drain_r;
    consume   = 1'b0;
    emit      = 1'b0;
    emit_byte = win_r[0];
    emit_last = 1'b0;

    if (drain_r) begin
      // end of stream: flush held bytes, only an active run masks them
      if (out_free) begin
        emit      = 1'b1;
        emit_byte = (mask_r != '0) ? STAR_BYTE : win_r[0];
        if (mask_r != '0) mask_nxt = mask_r - MASK_W'(1);
        for (int k = 0; k < PATTERN_MAX - 1; k++) win_nxt[k] = win_r[k+1];
        win_nxt[PATTERN_MAX-1] = '0;
        held_nxt = held_r - HELD_W'(1);
        if (held_r == HELD_W'(1)) begin
          emit_last = 1'b1;
          drain_nxt = 1'b0;
          mask_nxt  = '0;
        end
      end
    end else if (ib_valid_r && (held_r != '0) && (held_ext >= len_eff)) begin
      // at least as many bytes held as the current length: release the oldest, no compare
      if (out_free) begin
        emit      = 1'b1;
        emit_byte = (mask_r != '0) ? STAR_BYTE : win_r[0];
        if (mask_r != '0) mask_nxt = mask_r - MASK_W'(1);
        for (int k = 0; k < PATTERN_MAX - 1; k++) win_nxt[k] = win_r[k+1];
        win_nxt[PATTERN_MAX-1] = '0;
        held_nxt = held_r - HELD_W'(1);
      end
    end else if (ib_valid_r) begin
      if (len_eff == '0) begin
        // pass-through
        if (out_free) begin
          consume   = 1'b1;
          emit      = 1'b1;
          emit_byte = ib_byte_r;
          emit_last = ib_eos_r;
          mask_nxt  = '0;
        end
      end else if (!((newheld >= len_eff) || ib_eos_r)) begin
        // window still filling, nothing leaves
        consume  = 1'b1;
        win_nxt  = w_push;
        held_nxt = newheld[HELD_W-1:0];
      end else if (out_free) begin
        consume = 1'b1;
        emit    = 1'b1;
        if (mask_r != '0) begin
          star     = 1'b1;
          mask_nxt = mask_r - MASK_W'(1);
        end else if ((newheld == len_eff) && match) begin
          // match starts a run over the rest of the pattern
          star     = 1'b1;
          mask_nxt = MASK_W'(len_eff - LEN_W'(1));
        end
        emit_byte = star ? STAR_BYTE : w_push[0];
        for (int k = 0; k < PATTERN_MAX - 1; k++) win_nxt[k] = w_push[k+1];
        win_nxt[PATTERN_MAX-1] = '0;
        held_nxt = held_r;
        if (ib_eos_r) begin
          if (held_r == '0) begin
            emit_last = 1'b1;
            mask_nxt  = '0;
          end else begin
            drain_nxt = 1'b1;
          end
        end
      end
    end
  end

  assign in_stall = ib_valid_r && !consume;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r     <= '0;
      pat_len_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PATTERN_BYTES:  pat_r     <= cfg_wdata;
        CFG_PATTERN_LENGTH: pat_len_r <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // input register: refills in the same cycle it is consumed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ib_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      ib_valid_r <= 1'b1;
    end else if (consume) begin
      ib_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      ib_byte_r <= in_data_byte;
      ib_eos_r  <= in_end_of_stream;
    end
  end

  // window state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < PATTERN_MAX; k++) win_r[k] <= '0;
      held_r  <= '0;
      mask_r  <= '0;
      drain_r <= 1'b0;
    end else begin
      win_r   <= win_nxt;
      held_r  <= held_nxt;
      mask_r  <= mask_nxt;
      drain_r <= drain_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && emit) begin
      out_byte_r <= emit_byte;
      out_last_r <= emit_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

endmodule
